@@ sv/clnf_pkg.sv @@
// Shared types and constants of the character-LCD number formatter.
`timescale 1ns / 1ps

package clnf_pkg;

    // Request operation codes.
    localparam logic [2:0] OP_INIT = 3'd0;
    localparam logic [2:0] OP_CHAR = 3'd1;
    localparam logic [2:0] OP_UDEC = 3'd2;
    localparam logic [2:0] OP_SDEC = 3'd3;
    localparam logic [2:0] OP_HEX  = 3'd4;
    localparam logic [2:0] OP_BIN  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FUNCTION_SET    = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_CONTROL = 2'd1;
    localparam logic [1:0] CFG_ENTRY_MODE      = 2'd2;

    // Reset values of the set-up words.
    localparam logic [7:0] FUNCTION_SET_RST    = 8'h38;
    localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h0C;
    localparam logic [7:0] ENTRY_MODE_RST      = 8'h06;

    // LCD command and character constants.
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [7:0] LINE2_OFFSET = 8'h40;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_A         = 8'h41;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;

    // Digit limits.
    localparam logic [4:0] MAX_DIGITS = 5'd16;
    localparam int         DEC_DIGITS = 5;
    localparam logic [3:0] CONV_LAST  = 4'd15;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CONV,
        ST_INIT,
        ST_ADDR,
        ST_CHAR,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    // Source of the byte of an emitted bus write.
    typedef enum logic [2:0] {
        SEL_FSET,
        SEL_DCTL,
        SEL_EMODE,
        SEL_CLEAR,
        SEL_ADDR,
        SEL_GLYPH,
        SEL_SIGN,
        SEL_DIGIT
    } sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       emit;
        sel_t       sel;
        logic [3:0] digit_pos;
        logic       last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic [4:0] dcount;
        logic       out_free;
    } status_t;

endpackage

@@ sv/clnf_ctrl.sv @@
// Controller state machine that sequences the bus writes of one request.
`timescale 1ns / 1ps

module clnf_ctrl
    import clnf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_ADDR;
        cmd.digit_pos = cnt_reg[3:0] - 4'd1;
        cmd.last      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cnt_next = '0;
                if (st.op == OP_INIT) begin
                    state_next = ST_INIT;
                end else if (st.op == OP_UDEC || st.op == OP_SDEC) begin
                    state_next = ST_CONV;
                end else if (st.op == OP_CHAR || st.op == OP_HEX || st.op == OP_BIN) begin
                    state_next = ST_ADDR;
                end else begin
                    // Unused operation codes produce no writes.
                    state_next = ST_IDLE;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg[3:0] == CONV_LAST) begin
                    state_next = ST_ADDR;
                end
            end
            ST_INIT: begin
                case (cnt_reg[1:0])
                    2'd0:    cmd.sel = SEL_FSET;
                    2'd1:    cmd.sel = SEL_DCTL;
                    2'd2:    cmd.sel = SEL_EMODE;
                    default: cmd.sel = SEL_CLEAR;
                endcase
                cmd.last = (cnt_reg[1:0] == 2'd3);
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg[1:0] == 2'd3) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ADDR: begin
                cmd.sel  = SEL_ADDR;
                cmd.last = (st.op != OP_CHAR) && (st.op != OP_SDEC) && (st.dcount == 5'd0);
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cnt_next = st.dcount;
                    if (st.op == OP_CHAR) begin
                        state_next = ST_CHAR;
                    end else if (st.op == OP_SDEC) begin
                        state_next = ST_SIGN;
                    end else if (st.dcount == 5'd0) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_CHAR: begin
                cmd.sel  = SEL_GLYPH;
                cmd.last = 1'b1;
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN: begin
                cmd.sel  = SEL_SIGN;
                cmd.last = (st.dcount == 5'd0);
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = (st.dcount == 5'd0) ? ST_IDLE : ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                cmd.sel  = SEL_DIGIT;
                cmd.last = (cnt_reg == 5'd1);
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A write is only issued when the output register can take it.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> st.out_free)
        else $error("write issued while output register busy");

    // The final write of a request returns the controller to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> state_reg == ST_IDLE)
        else $error("controller not idle after final write");

    // Digit emission never runs with an exhausted digit counter.
    a_digit_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIGIT |-> cnt_reg != 5'd0)
        else $error("digit state with zero count");

    // Decimal conversion runs only for decimal requests.
    a_conv_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CONV |-> (st.op == OP_UDEC || st.op == OP_SDEC))
        else $error("conversion for a non-decimal request");

endmodule

@@ sv/clnf_datapath.sv @@
// Datapath: request registers, set-up words, decimal conversion and output register.
`timescale 1ns / 1ps

module clnf_datapath
    import clnf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [39:0] s_tdata,   // operation, line, column, value, glyph, digit_count
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  cmd_t        cmd,
    output status_t     st,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_byte
    output logic        m_tuser,   // is_data
    output logic        m_tlast
);

    // Input fields.
    logic [2:0]  in_op;
    logic [1:0]  in_line;
    logic [5:0]  in_column;
    logic [15:0] in_value;
    logic [7:0]  in_glyph;
    logic [4:0]  in_count;

    assign in_op     = s_tdata[2:0];
    assign in_line   = s_tdata[4:3];
    assign in_column = s_tdata[10:5];
    assign in_value  = s_tdata[26:11];
    assign in_glyph  = s_tdata[34:27];
    assign in_count  = s_tdata[39:35];

    logic [7:0]  fset_reg, dctl_reg, emode_reg;
    logic [2:0]  op_reg;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  glyph_reg;
    logic [4:0]  dcount_reg, dcount_next;
    logic [15:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [15:0] sh_reg;
    logic [19:0] bcd_reg, bcd_adj;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        is_data_reg, is_data_next;
    logic        last_reg;
    logic [3:0]  digit;
    logic [7:0]  digit_char;

    // Set-up word registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fset_reg  <= FUNCTION_SET_RST;
            dctl_reg  <= DISPLAY_CONTROL_RST;
            emode_reg <= ENTRY_MODE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FUNCTION_SET:    fset_reg  <= cfg_wdata;
                CFG_DISPLAY_CONTROL: dctl_reg  <= cfg_wdata;
                CFG_ENTRY_MODE:      emode_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Request decoding at load time.
    always_comb begin
        addr_next   = {2'b00, in_column} + 8'hFF + ((in_line != 2'd1) ? LINE2_OFFSET : 8'h00);
        dcount_next = (in_count > MAX_DIGITS) ? MAX_DIGITS : in_count;
        neg_next    = (in_op == OP_SDEC) && in_value[15];
        mag_next    = neg_next ? (16'd0 - in_value) : in_value;
    end

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    // Request and conversion registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_op;
            addr_reg   <= addr_next;
            glyph_reg  <= in_glyph;
            dcount_reg <= dcount_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            sh_reg     <= mag_next;
            bcd_reg    <= '0;
        end else if (cmd.conv_step) begin
            sh_reg  <= {sh_reg[14:0], 1'b0};
            bcd_reg <= {bcd_adj[18:0], sh_reg[15]};
        end
    end

    // Digit at the requested position; positions past the value's width read zero.
    always_comb begin
        digit = 4'd0;
        if (op_reg == OP_HEX) begin
            if (cmd.digit_pos < 4'd4) begin
                digit = mag_reg[{cmd.digit_pos[1:0], 2'b00} +: 4];
            end
        end else if (op_reg == OP_BIN) begin
            digit = {3'b000, mag_reg[cmd.digit_pos]};
        end else begin
            if (cmd.digit_pos < 4'(DEC_DIGITS)) begin
                digit = bcd_reg[{cmd.digit_pos[2:0], 2'b00} +: 4];
            end
        end
        digit_char = (digit < 4'd10) ? (CH_ZERO + {4'd0, digit})
                                     : (CH_A + {4'd0, digit} - 8'd10);
    end

    // Byte selection for the write being issued.
    always_comb begin
        byte_next    = CMD_CLEAR;
        is_data_next = 1'b0;
        unique case (cmd.sel)
            SEL_FSET:  byte_next = fset_reg;
            SEL_DCTL:  byte_next = dctl_reg;
            SEL_EMODE: byte_next = emode_reg;
            SEL_CLEAR: byte_next = CMD_CLEAR;
            SEL_ADDR:  byte_next = CMD_DDRAM | addr_reg;
            SEL_GLYPH: begin
                byte_next    = glyph_reg;
                is_data_next = 1'b1;
            end
            SEL_SIGN: begin
                byte_next    = neg_reg ? CH_MINUS : CH_PLUS;
                is_data_next = 1'b1;
            end
            SEL_DIGIT: begin
                byte_next    = digit_char;
                is_data_next = 1'b1;
            end
            default: byte_next = CMD_CLEAR;
        endcase
    end

    // Output register.
    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            byte_reg    <= byte_next;
            is_data_reg <= is_data_next;
            last_reg    <= cmd.last;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = byte_reg;
    assign m_tuser     = is_data_reg;
    assign m_tlast     = last_reg;
    assign st.op       = op_reg;
    assign st.dcount   = dcount_reg;
    assign st.out_free = !m_tvalid_reg || m_tready;

endmodule

@@ sv/char_lcd_number_formatter.sv @@
// Throughput: one bus write per cycle while the result side is ready; decimal requests first run
// a serial BCD conversion before their first write.
// A new item is accepted once the controller has issued the last write of the previous one.
// Reset (aresetn low, synchronous) empties the output register and restores the set-up words.
`timescale 1ns / 1ps

module char_lcd_number_formatter
    import clnf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation, line, column, value, glyph, digit_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_byte
    output logic        m_tuser,   // is_data
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    cmd_t    cmd;
    status_t st;

    // Sequencing of the writes.
    clnf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Byte formation and output register.
    clnf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the character-LCD number formatter.
`timescale 1ns / 1ps

module testbench;
    import clnf_pkg::*;

    // Operation codes the block does not use, and the register index it ignores.
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Quiet cycles after the last write, and the stall limit of the watchdog.
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 4000;
    localparam int ITEMS_PER_PASS = 26;

    // One display request as it travels on the input channel.
    typedef struct {
        logic [2:0]  op;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [15:0] value;
        logic [7:0]  glyph;
        logic [4:0]  dcount;
    } req_t;

    // One LCD bus write as it leaves the block.
    typedef struct {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // operation, line, column, value, glyph, digit_count
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // bus_byte
    logic        m_tuser;        // is_data
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;

    req_t       pending_reqs[$];
    lcd_write_t writes_due[$];
    req_t       offered;
    int         gap_left;
    int         stall_left;
    int         stall_cycles = 0;
    int         errors = 0;
    bit         idle_on = 1'b1;

    // Our copy of the set-up words.
    logic [7:0] fset_word  = FUNCTION_SET_RST;
    logic [7:0] dctl_word  = DISPLAY_CONTROL_RST;
    logic [7:0] emode_word = ENTRY_MODE_RST;

    char_lcd_number_formatter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // Wait drawn for every item on either side; none while idling is switched off.
    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, 4)) : 0;
    endfunction

    function automatic void push_write(input logic is_data, input logic [7:0] bus_byte);
        lcd_write_t w;
        w.is_data  = is_data;
        w.bus_byte = bus_byte;
        w.last     = 1'b0;
        writes_due.push_back(w);
    endfunction

    // Works out the bus writes that one request causes and queues them.
    function automatic void queue_writes(input req_t r);
        logic [7:0]      addr;
        logic [4:0]      ndig;
        longint unsigned mag;
        longint unsigned scale;
        int unsigned     base;
        int unsigned     digit;
        if (r.op == OP_INIT) begin
            push_write(1'b0, fset_word);
            push_write(1'b0, dctl_word);
            push_write(1'b0, emode_word);
            push_write(1'b0, CMD_CLEAR);
            writes_due[writes_due.size() - 1].last = 1'b1;
            return;
        end
        if (r.op > OP_BIN) begin
            return;
        end

        // Cursor address; column zero wraps round.
        addr = 8'(r.column) + 8'hFF + ((r.line != 2'd1) ? LINE2_OFFSET : 8'h00);
        push_write(1'b0, CMD_DDRAM | addr);
        if (r.op == OP_CHAR) begin
            push_write(1'b1, r.glyph);
            writes_due[writes_due.size() - 1].last = 1'b1;
            return;
        end

        ndig = (r.dcount > MAX_DIGITS) ? MAX_DIGITS : r.dcount;
        mag  = r.value;
        base = 10;
        case (r.op)
            OP_SDEC: begin
                if (r.value[15]) begin
                    push_write(1'b1, CH_MINUS);
                    mag = 64'h10000 - r.value;
                end else begin
                    push_write(1'b1, CH_PLUS);
                end
            end
            OP_HEX:  base = 16;
            OP_BIN:  base = 2;
            default: ;
        endcase

        // Digits, most significant first; positions past the value give zero.
        for (int k = int'(ndig) - 1; k >= 0; k--) begin
            scale = 1;
            for (int j = 0; j < k; j++) begin
                scale = scale * base;
            end
            digit = int'((mag / scale) % base);
            push_write(1'b1, (digit < 10) ? CH_ZERO + 8'(digit) : CH_A + 8'(digit - 10));
        end
        writes_due[writes_due.size() - 1].last = 1'b1;
    endfunction

    // Input driver: offers queued requests and records each accepted one.
    always @(posedge aclk) begin : request_driver
        bit holding;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            holding = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                queue_writes(offered);
                gap_left = draw_wait();
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offered = pending_reqs.pop_front();
                    s_tdata <= {offered.dcount, offered.glyph, offered.value,
                                offered.column, offered.line, offered.op};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted write against the oldest one due.
    always @(posedge aclk) begin : result_monitor
        lcd_write_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (writes_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected write byte %h user %b last %b",
                                            m_tdata, m_tuser, m_tlast));
                end else begin
                    want = writes_due.pop_front();
                    if (m_tuser !== want.is_data) begin
                        note_mismatch($sformatf("is_data %b, want %b (byte %h)",
                                                m_tuser, want.is_data, want.bus_byte));
                    end
                    if (m_tdata !== want.bus_byte) begin
                        note_mismatch($sformatf("bus_byte %h, want %h", m_tdata, want.bus_byte));
                    end
                    if (m_tlast !== want.last) begin
                        note_mismatch($sformatf("last %b, want %b (byte %h)",
                                                m_tlast, want.last, want.bus_byte));
                    end
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic void add_req(input logic [2:0] op, input logic [1:0] line,
                                    input logic [5:0] column, input logic [15:0] value,
                                    input logic [7:0] glyph, input logic [4:0] dcount);
        req_t r;
        r.op     = op;
        r.line   = line;
        r.column = column;
        r.value  = value;
        r.glyph  = glyph;
        r.dcount = dcount;
        pending_reqs.push_back(r);
    endfunction

    // Queues one random request; returns whether the block will answer it.
    function automatic bit add_random_req();
        logic [2:0]  op;
        logic [5:0]  column;
        logic [15:0] value;
        logic [4:0]  dcount;
        int unsigned pick;
        pick   = $urandom_range(0, 99);
        op     = (pick < 4) ? (pick[0] ? OP_SPARE7 : OP_SPARE6) : 3'($urandom_range(0, 5));
        column = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(1, 40));
        case ($urandom_range(0, 9))
            0:       value = 16'h0000;
            1:       value = 16'hFFFF;
            2:       value = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            default: value = 16'($urandom_range(0, 65535));
        endcase
        dcount = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 16));
        add_req(op, 2'($urandom_range(0, 3)), column, value, 8'($urandom_range(0, 255)), dcount);
        return op <= OP_BIN;
    endfunction

    // Writes one set-up register and keeps our copy in step.
    task automatic write_setup(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FUNCTION_SET:    fset_word  = val;
            CFG_DISPLAY_CONTROL: dctl_word  = val;
            CFG_ENTRY_MODE:      emode_word = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Holds the sender back until every due write has come and the block is quiet.
    task automatic wait_quiet();
        do begin
            @(negedge aclk);
        end while (pending_reqs.size() != 0 || s_tvalid || writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Stimulus: a pass at reset settings with directed and random requests, then random passes under new set-up words.
    initial begin
        int counted;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int pass = 0; pass < 5; pass++) begin
            idle_on = (pass % 2 == 0);
            case (pass)
                1: begin
                    write_setup(CFG_FUNCTION_SET, 8'($urandom_range(0, 255)));
                    write_setup(CFG_DISPLAY_CONTROL, 8'($urandom_range(0, 255)));
                    write_setup(CFG_ENTRY_MODE, 8'($urandom_range(0, 255)));
                end
                2: begin
                    write_setup(CFG_FUNCTION_SET, 8'h00);
                    write_setup(CFG_DISPLAY_CONTROL, 8'h00);
                    write_setup(CFG_ENTRY_MODE, 8'h00);
                end
                3: begin
                    write_setup(CFG_FUNCTION_SET, 8'hFF);
                    write_setup(CFG_DISPLAY_CONTROL, 8'hFF);
                    write_setup(CFG_ENTRY_MODE, 8'hFF);
                end
                4: begin
                    write_setup(CFG_ENTRY_MODE, 8'($urandom_range(0, 255)));
                    write_setup(CFG_SPARE, 8'($urandom_range(0, 255)));
                    write_setup(CFG_FUNCTION_SET, 8'($urandom_range(0, 255)));
                end
                default: ;
            endcase

            if (pass == 0) begin
                // Extremes of every field, every operation and the corner cases.
                add_req(OP_INIT, 2'd3, 6'd63, 16'hFFFF, 8'hFF, 5'd31);
                add_req(OP_CHAR, 2'd1, 6'd1, 16'h1234, 8'h00, 5'd7);
                add_req(OP_CHAR, 2'd2, 6'd40, 16'h0000, 8'hFF, 5'd0);
                add_req(OP_CHAR, 2'd3, 6'd0, 16'hFFFF, 8'h41, 5'd31);
                add_req(OP_UDEC, 2'd0, 6'd63, 16'hFFFF, 8'h00, 5'd5);
                add_req(OP_UDEC, 2'd1, 6'd1, 16'h0000, 8'h00, 5'd16);
                add_req(OP_UDEC, 2'd2, 6'd12, 16'd12345, 8'h00, 5'd3);
                add_req(OP_UDEC, 2'd1, 6'd5, 16'd999, 8'h00, 5'd0);
                add_req(OP_SDEC, 2'd1, 6'd2, 16'h8000, 8'h00, 5'd5);
                add_req(OP_SDEC, 2'd2, 6'd3, 16'h7FFF, 8'h00, 5'd5);
                add_req(OP_SDEC, 2'd1, 6'd4, 16'hFFFF, 8'h00, 5'd1);
                add_req(OP_SDEC, 2'd2, 6'd9, 16'h0000, 8'h00, 5'd0);
                add_req(OP_SDEC, 2'd1, 6'd7, 16'hFFFF, 8'h00, 5'd16);
                add_req(OP_HEX, 2'd1, 6'd10, 16'hBEEF, 8'h00, 5'd4);
                add_req(OP_HEX, 2'd2, 6'd20, 16'hA5C3, 8'h00, 5'd16);
                add_req(OP_BIN, 2'd1, 6'd30, 16'hFFFF, 8'h00, 5'd16);
                add_req(OP_BIN, 2'd2, 6'd1, 16'h5555, 8'h00, 5'd31);
                add_req(OP_SPARE6, 2'd1, 6'd1, 16'h1234, 8'h55, 5'd4);
                add_req(OP_SPARE7, 2'd2, 6'd2, 16'hFFFF, 8'hAA, 5'd16);
                add_req(OP_HEX, 2'd1, 6'd0, 16'h00FF, 8'h00, 5'd2);
                add_req(OP_UDEC, 2'd3, 6'd0, 16'd65535, 8'h00, 5'd20);
            end else begin
                // The set-up words show up only in an init request.
                add_req(OP_INIT, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                        16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                        5'($urandom_range(0, 31)));
            end

            counted = 0;
            while (counted < ITEMS_PER_PASS) begin
                if (add_random_req()) begin
                    counted++;
                end
            end
            wait_quiet();
        end

        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
